>>> src/hcfs_pkg.sv
// Shared constants and types for the heating curve feed setpoint block.
package hcfs_pkg;

    localparam int TEMP_FRAC_BITS = 4;
    localparam int TEMP_W         = 12;
    localparam int HALF_W         = 9;
    localparam int ACC_W          = 48;
    localparam int MUL_A_W        = 32;
    localparam int MUL_B_W        = 16;
    localparam int NUM_W          = ACC_W + 1;
    localparam int DEN_W          = ACC_W + TEMP_FRAC_BITS;
    localparam int RES_W          = NUM_W + TEMP_FRAC_BITS;
    localparam int CNT_W          = $clog2(NUM_W + 1);

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(2047);
    localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(2048);

    localparam logic [2:0] PATH_INACTIVE = 3'd0;
    localparam logic [2:0] PATH_OVERRIDE = 3'd1;
    localparam logic [2:0] PATH_FLAT     = 3'd2;
    localparam logic [2:0] PATH_BOOST    = 3'd3;
    localparam logic [2:0] PATH_VALVE    = 3'd4;
    localparam logic [2:0] PATH_CURVE    = 3'd5;
    localparam logic [2:0] PATH_HEATUP   = 3'd6;
    localparam logic [2:0] PATH_REJECT   = 3'd7;

    localparam logic [2:0] REG_BASE     = 3'd0;
    localparam logic [2:0] REG_END      = 3'd1;
    localparam logic [2:0] REG_MIN      = 3'd2;
    localparam logic [2:0] REG_ADAPT    = 3'd3;
    localparam logic [2:0] REG_TARGET   = 3'd4;
    localparam logic [2:0] REG_MAXV     = 3'd5;
    localparam logic [2:0] REG_OVERRIDE = 3'd6;
    localparam logic [2:0] REG_MODE     = 3'd7;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

>>> src/hcfs_div.sv
// Iterative restoring divider with rounding to half degrees, ties away from zero.
module hcfs_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [hcfs_pkg::ACC_W-1:0]   num,
    input  logic signed [hcfs_pkg::ACC_W-1:0]   den,
    output logic                                done,
    output logic signed [hcfs_pkg::RES_W-1:0]   quo
);
    import hcfs_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DEN_W:0]          rem_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [DEN_W-1:0]        dvs_reg;
    logic                    neg_reg;
    logic signed [RES_W-1:0] res_reg;

    logic signed [ACC_W-1:0] nn;
    logic [ACC_W-1:0]        dd;
    logic [ACC_W-1:0]        mag;
    logic [DEN_W:0]          rem_sh;
    logic                    ge;
    logic [DEN_W:0]          rem_new;
    logic [NUM_W-1:0]        quo_new;
    logic signed [RES_W-1:0] q_shift;

    always_comb begin
        nn      = den[ACC_W-1] ? -num : num;
        dd      = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        mag     = nn[ACC_W-1] ? ACC_W'(-nn) : ACC_W'(nn);
        rem_sh  = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_new = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
        quo_new = {quo_reg[NUM_W-2:0], ge};
        q_shift = signed'(RES_W'(quo_new) << (TEMP_FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && cnt_reg == CNT_W'(NUM_W - 1);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= (NUM_W'(mag) << 1) + (NUM_W'(dd) << (TEMP_FRAC_BITS - 1));
            dvs_reg <= DEN_W'(dd) << TEMP_FRAC_BITS;
            neg_reg <= nn[ACC_W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                res_reg <= neg_reg ? -q_shift : q_shift;
            end
        end
    end

    assign done = done_reg;
    assign quo  = res_reg;

endmodule

>>> src/heating_curve_feed_setpoint.sv
// Top level: configuration registers, sequencer and shared multiplier of the feed setpoint.
// Usage:
//   Input channel s_tvalid/s_tready/s_tdata carries one sensor update per transaction.
//   Result channel m_tvalid/m_tready/m_tdata carries one setpoint result per update.
//   The APB port writes and reads the eight curve registers at byte address 4*index;
//   write only while no update is in flight.
// Sequencing:
//   Passthrough paths (inactive, override, flat, boost, zero maximum valve opening)
//   go straight to S_OUT. Valve scaling, the outside curve and fast heatup run their
//   divisions one quotient bit per cycle through the shared divider, and each
//   product goes through the one multiplier. s_tready is high only in the idle
//   state, so one update is in flight at a time; the next update can be accepted
//   in the cycle after a result is loaded.
// Reset (aresetn low, synchronous) restores register defaults, clears the heatup
//   flag and the reference room temperature, and empties the output register.
// A stalled receiver holds the result in the output register; the next update is
//   accepted meanwhile and its result waits until the register is free.
module heating_curve_feed_setpoint (
    input  logic        aclk,
    input  logic        aresetn,
    // heating_active[0], on_fallback[1], fallback_min_feed[13:2], boiler_feed_min[25:14],
    // boiler_feed_max[37:26], outside_temp[49:38], valve_opening[57:50],
    // return_temp[69:58], ambient_temp[81:70], fast_heatup_start[82], zero[87:83]
    input  logic [87:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // feed_setpoint[11:0], setpoint_half_steps[20:12], fast_heatup_active[21],
    // path_taken[24:22], zero[31:25]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hcfs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CALC = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_OUT  = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        K_VD = 2'd0,
        K_VS = 2'd1,
        K_CV = 2'd2,
        K_HU = 2'd3
    } kind_t;

    logic signed [11:0] base_reg, end_reg, min_reg, target_reg, override_reg;
    logic signed [9:0]  adapt_reg;
    logic [7:0]         maxv_reg;
    logic [3:0]         mode_reg;

    logic signed [11:0] bmax_reg, outside_reg, ret_reg, amb_reg, refr_reg;
    logic [7:0]         valve_reg;
    logic               flag_reg;

    state_t state_reg, state_next;
    kind_t  kind_reg;
    logic [2:0] pc_reg;
    logic [2:0] path_reg;

    logic signed [ACC_W-1:0] x_reg, y_reg, z_reg, n_reg, dn_reg;
    logic signed [RES_W-1:0] res_reg, curve_reg;

    logic [31:0] m_tdata_reg;
    logic        m_tvalid_reg;

    logic signed [11:0] in_fbmin, in_bmin, in_bmax, in_amb;
    logic               in_active, in_fallback, in_start;
    logic               s_acc, cfg_wr;

    logic signed [12:0] d13, cden13, ob13, oe13, bmr13, lo13, diff13, rdiff13;
    logic signed [13:0] bml14, adj14;
    logic signed [14:0] ra15;
    logic signed [8:0]  maxv9, valve9;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [ACC_W-1:0]           prod;
    logic                              last_step;
    div_ctl_t                          dctl;
    logic signed [RES_W-1:0]           div_q;

    logic signed [RES_W-1:0] res_sat_w;
    logic signed [11:0]      res_sat;
    logic signed [12:0]      half_sum;
    logic signed [12:0]      half_val;

    assign in_active   = s_tdata[0];
    assign in_fallback = s_tdata[1];
    assign in_fbmin    = signed'(s_tdata[13:2]);
    assign in_bmin     = signed'(s_tdata[25:14]);
    assign in_bmax     = signed'(s_tdata[37:26]);
    assign in_amb      = signed'(s_tdata[81:70]);
    assign in_start    = s_tdata[82];

    assign s_tready = state_reg == S_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= -12'sd240;
            end_reg      <= 12'sd400;
            min_reg      <= 12'sd160;
            adapt_reg    <= 10'sd0;
            target_reg   <= 12'sd336;
            maxv_reg     <= 8'd100;
            override_reg <= 12'sd640;
            mode_reg     <= 4'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_BASE:     base_reg     <= signed'(pwdata[11:0]);
                REG_END:      end_reg      <= signed'(pwdata[11:0]);
                REG_MIN:      min_reg      <= signed'(pwdata[11:0]);
                REG_ADAPT:    adapt_reg    <= signed'(pwdata[9:0]);
                REG_TARGET:   target_reg   <= signed'(pwdata[11:0]);
                REG_MAXV:     maxv_reg     <= pwdata[7:0];
                REG_OVERRIDE: override_reg <= signed'(pwdata[11:0]);
                REG_MODE:     mode_reg     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_BASE:     prdata = {20'd0, base_reg};
            REG_END:      prdata = {20'd0, end_reg};
            REG_MIN:      prdata = {20'd0, min_reg};
            REG_ADAPT:    prdata = {22'd0, adapt_reg};
            REG_TARGET:   prdata = {20'd0, target_reg};
            REG_MAXV:     prdata = {24'd0, maxv_reg};
            REG_OVERRIDE: prdata = {20'd0, override_reg};
            REG_MODE:     prdata = {28'd0, mode_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_comb begin
        d13     = 13'(end_reg) - 13'(base_reg);
        cden13  = 13'(base_reg) - 13'(end_reg);
        ob13    = 13'(outside_reg) - 13'(base_reg);
        oe13    = 13'(outside_reg) - 13'(end_reg);
        bmr13   = 13'(bmax_reg) - 13'(min_reg);
        lo13    = 13'(min_reg) + 13'(adapt_reg);
        bml14   = 14'(bmax_reg) - 14'(lo13);
        diff13  = 13'(target_reg) - 13'(amb_reg);
        rdiff13 = 13'(target_reg) - 13'(refr_reg);
        adj14   = (mode_reg[3] && !flag_reg) ?
                  14'(adapt_reg) + 14'(target_reg) - 14'(ret_reg) : 14'(adapt_reg);
        ra15    = 15'(min_reg) + 15'(adj14);
        maxv9   = signed'({1'b0, maxv_reg});
        valve9  = signed'({1'b0, valve_reg});
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        last_step = 1'b0;
        case (kind_reg)
            K_VD: begin
                case (pc_reg)
                    3'd0: begin mul_a = MUL_A_W'(ob13);   mul_b = MUL_B_W'(adapt_reg); end
                    3'd1: begin mul_a = MUL_A_W'(bmax_reg); mul_b = MUL_B_W'(d13); end
                    3'd2: begin mul_a = MUL_A_W'(min_reg); mul_b = MUL_B_W'(d13); end
                    3'd3: begin
                        mul_a = MUL_A_W'(y_reg - z_reg - x_reg);
                        mul_b = MUL_B_W'(valve9);
                    end
                    3'd4: begin mul_a = MUL_A_W'(z_reg); mul_b = MUL_B_W'(maxv9); end
                    3'd5: begin mul_a = MUL_A_W'(x_reg); mul_b = MUL_B_W'(maxv9); end
                    3'd7: begin
                        mul_a     = MUL_A_W'(d13);
                        mul_b     = MUL_B_W'(maxv9);
                        last_step = 1'b1;
                    end
                    default: ;
                endcase
            end
            K_VS: begin
                case (pc_reg)
                    3'd0: begin mul_a = MUL_A_W'(lo13); mul_b = MUL_B_W'(maxv9); end
                    3'd1: begin mul_a = MUL_A_W'(bml14); mul_b = MUL_B_W'(valve9); end
                    3'd2: last_step = 1'b1;
                    default: ;
                endcase
            end
            K_CV: begin
                case (pc_reg)
                    3'd0: begin mul_a = MUL_A_W'(oe13); mul_b = MUL_B_W'(bmr13); end
                    3'd1: begin mul_a = MUL_A_W'(ra15); mul_b = MUL_B_W'(cden13); end
                    3'd3: begin
                        mul_a     = MUL_A_W'(bmax_reg);
                        mul_b     = MUL_B_W'(cden13);
                        last_step = 1'b1;
                    end
                    default: ;
                endcase
            end
            K_HU: begin
                case (pc_reg)
                    3'd0: begin mul_a = MUL_A_W'(x_reg - n_reg); mul_b = MUL_B_W'(diff13); end
                    3'd1: begin mul_a = MUL_A_W'(n_reg); mul_b = MUL_B_W'(rdiff13); end
                    3'd2: begin mul_a = MUL_A_W'(dn_reg); mul_b = MUL_B_W'(rdiff13); end
                    3'd3: last_step = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

    assign dctl.start = state_reg == S_LOAD;

    hcfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dctl.start),
        .num     (n_reg),
        .den     (dn_reg),
        .done    (dctl.done),
        .quo     (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (!in_active || mode_reg[0] || base_reg == end_reg || mode_reg[1]
                        || (mode_reg[2] && maxv_reg == 8'd0)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:  if (last_step) state_next = S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV: begin
                if (dctl.done) begin
                    if (kind_reg == K_CV && flag_reg && amb_reg < target_reg
                        && n_reg != x_reg && rdiff13 != 13'sd0) begin
                        state_next = S_CALC;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:   state_next = S_HOLD;
            S_HOLD:  if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            flag_reg     <= 1'b0;
            refr_reg     <= 12'sd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_HOLD && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_acc && in_start) refr_reg <= in_amb;
            if (s_acc && in_active && !mode_reg[0] && base_reg != end_reg && !mode_reg[1]
                && mode_reg[2]) begin
                flag_reg <= 1'b0;
            end else if (s_acc && in_start) begin
                flag_reg <= 1'b1;
            end else if (state_reg == S_DIV && dctl.done && kind_reg == K_CV && flag_reg
                         && amb_reg >= target_reg) begin
                flag_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    bmax_reg    <= in_bmax;
                    outside_reg <= signed'(s_tdata[49:38]);
                    valve_reg   <= s_tdata[57:50];
                    ret_reg     <= signed'(s_tdata[69:58]);
                    amb_reg     <= in_amb;
                    pc_reg      <= 3'd0;
                    kind_reg    <= mode_reg[2] ? (mode_reg[3] ? K_VD : K_VS) : K_CV;
                    if (!in_active) begin
                        res_reg  <= RES_W'(in_fallback ? in_fbmin : in_bmin);
                        path_reg <= PATH_INACTIVE;
                    end else if (mode_reg[0]) begin
                        res_reg  <= RES_W'(override_reg);
                        path_reg <= PATH_OVERRIDE;
                    end else if (base_reg == end_reg) begin
                        res_reg  <= RES_W'(base_reg);
                        path_reg <= PATH_FLAT;
                    end else if (mode_reg[1]) begin
                        res_reg  <= RES_W'(in_bmax);
                        path_reg <= PATH_BOOST;
                    end else if (mode_reg[2]) begin
                        res_reg  <= RES_W'(in_bmax);
                        path_reg <= PATH_VALVE;
                    end else begin
                        path_reg <= PATH_CURVE;
                    end
                end
            end
            S_CALC: begin
                pc_reg <= pc_reg + 3'd1;
                case (kind_reg)
                    K_VD: begin
                        case (pc_reg)
                            3'd0: x_reg <= prod;
                            3'd1: y_reg <= prod;
                            3'd2: z_reg <= prod;
                            3'd3: y_reg <= prod;
                            3'd4: z_reg <= prod;
                            3'd5: x_reg <= prod;
                            3'd6: n_reg <= x_reg + y_reg + z_reg;
                            3'd7: dn_reg <= prod;
                            default: ;
                        endcase
                    end
                    K_VS: begin
                        case (pc_reg)
                            3'd0: x_reg <= prod;
                            3'd1: y_reg <= prod;
                            3'd2: begin
                                n_reg  <= x_reg + y_reg;
                                dn_reg <= ACC_W'(maxv9);
                            end
                            default: ;
                        endcase
                    end
                    K_CV: begin
                        case (pc_reg)
                            3'd0: x_reg <= prod;
                            3'd1: y_reg <= prod;
                            3'd2: begin
                                n_reg  <= x_reg + y_reg;
                                dn_reg <= ACC_W'(cden13);
                            end
                            3'd3: x_reg <= prod;
                            default: ;
                        endcase
                    end
                    K_HU: begin
                        case (pc_reg)
                            3'd0: y_reg <= prod;
                            3'd1: z_reg <= prod;
                            3'd2: dn_reg <= prod;
                            3'd3: n_reg <= y_reg + z_reg;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                if (dctl.done) begin
                    pc_reg <= 3'd0;
                    case (kind_reg)
                        K_CV: begin
                            curve_reg <= div_q;
                            if (flag_reg && amb_reg < target_reg) begin
                                path_reg <= PATH_HEATUP;
                                if (n_reg == x_reg || rdiff13 == 13'sd0) begin
                                    res_reg <= RES_W'(bmax_reg);
                                end else begin
                                    res_reg  <= div_q;
                                    kind_reg <= K_HU;
                                end
                            end else begin
                                res_reg <= div_q;
                            end
                        end
                        K_HU: begin
                            if (div_q > RES_W'(bmax_reg)) begin
                                res_reg  <= curve_reg;
                                path_reg <= PATH_REJECT;
                            end else begin
                                res_reg <= div_q;
                            end
                        end
                        default: res_reg <= div_q;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (res_reg > SAT_HI) begin
            res_sat_w = SAT_HI;
        end else if (res_reg < SAT_LO) begin
            res_sat_w = SAT_LO;
        end else begin
            res_sat_w = res_reg;
        end
        res_sat  = res_sat_w[11:0];
        half_sum = res_sat[11] ? 13'(res_sat) + 13'((1 << (TEMP_FRAC_BITS - 1)) - 1)
                               : 13'(res_sat);
        half_val = half_sum >>> (TEMP_FRAC_BITS - 1);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_HOLD && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {7'd0, path_reg, flag_reg, half_val[HALF_W-1:0], res_sat};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
